// ===== src/ahicp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the ASCII hex I2C command parser.
// No dependencies; every other file imports this package.
package ahicp_pkg;

    localparam logic [2:0] CMD_IDLE    = 3'd0;
    localparam logic [2:0] CMD_GET     = 3'd1;
    localparam logic [2:0] CMD_COMMENT = 3'd2;
    localparam logic [2:0] CMD_RAW     = 3'd3;
    localparam logic [2:0] CMD_READ    = 3'd4;
    localparam logic [2:0] CMD_WRITE   = 3'd5;
    localparam logic [2:0] CMD_WAIT    = 3'd6;

    localparam logic [2:0] SUB_ADDR     = 3'd0;
    localparam logic [2:0] SUB_RD_LEN   = 3'd1;
    localparam logic [2:0] SUB_RS_STOP  = 3'd2;
    localparam logic [2:0] SUB_WR_DATA  = 3'd3;
    localparam logic [2:0] SUB_REG      = 3'd4;
    localparam logic [2:0] SUB_LEN_EOL  = 3'd5;
    localparam logic [2:0] SUB_DATA_EOL = 3'd6;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_ESCAPE = 2'd2;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_CMD  = 3'd1;
    localparam logic [2:0] ERR_HEX  = 3'd2;
    localparam logic [2:0] ERR_DATA = 3'd3;
    localparam logic [2:0] ERR_INT  = 3'd4;

    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] DATA_MARK = 8'h01;

    // All results caused by one character.
    typedef struct packed {
        logic [2:0]       cnt;
        logic [2:0]       err;
        logic             done;
        logic             start;
        logic [3:0][7:0]  bytes;
    } res_t;

endpackage

// ===== src/ascii_hex_i2c_command_parser.sv =====
`timescale 1ns / 1ps
// Top level of the ASCII hex I2C command parser: input register, parser and result emitter.
// Depends on ahicp_pkg, ahicp_parser and ahicp_emitter.
//
// The block takes one ASCII character per item and turns line commands into an encoded
// I2C byte stream. Each character gives zero to four result items; an error gives exactly
// one item with tuser bit 0 set and the error code in tdata bits 10:8. The character is
// held in an input register and parsed combinationally; its results are loaded into a
// result register, from which the output port sends one item per cycle while m_axis_tready
// is high. The parser takes a held character only while the result register is empty or
// its last item is being taken; the first result is offered once the result register is
// loaded. The input accepts a new character while earlier results are still being sent.
module ascii_hex_i2c_command_parser
    import ahicp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_in[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_byte[7:0], err_id[10:8], zero[15:11]
    output logic [2:0]  m_axis_tuser,   // kind[0], buffer_start[1], command_done[2]
    output logic        m_axis_tlast
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg;
    logic       load_ok;
    logic       step;
    res_t       res;

    assign step = in_valid_reg && load_ok;
    assign s_axis_tready = !in_valid_reg || load_ok;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_char_reg <= s_axis_tdata;
        end
    end

    ahicp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .char_in (in_char_reg),
        .res     (res)
    );

    ahicp_emitter u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .res           (res),
        .load_ok       (load_ok),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_err_single : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata[7:0] == 8'h00)
        else $error("error item is not a single last item");

    a_done_last : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tlast && !m_axis_tuser[0])
        else $error("command done flagged on an item that is not the last byte");

    a_start_kind : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0] && m_axis_tdata[10:8] == ERR_NONE)
        else $error("buffer start flagged on an error item");

    a_step_input : assert property (@(posedge clk) disable iff (!rst_n)
        step |-> in_valid_reg && load_ok)
        else $error("parser stepped without a held character");
`endif

endmodule

// ===== src/ahicp_parser.sv =====
`timescale 1ns / 1ps
// Parser state registers and the single-pass next-state and result logic.
// Depends on ahicp_pkg.
module ahicp_parser
    import ahicp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] char_in,
    output res_t       res
);

    logic [2:0] cmd_reg, cmd_next;
    logic [2:0] sub_reg, sub_next;
    logic [1:0] mph_reg, mph_next;
    logic       hph_reg, hph_next;
    logic [7:0] data_reg, data_next;
    logic [7:0] addr_reg, addr_next;
    logic [7:0] len_reg, len_next;
    logic       fresh_reg, fresh_next;

    always_comb
    begin
        logic [7:0] c;
        logic       eol;
        logic       hv;
        logic [3:0] hn;
        logic       fr0;
        logic       th_ok, th_err, th_hp;
        logic [7:0] th_db;
        logic       dc_go, allow;
        logic [2:0] n;
        logic [2:0] err;
        logic       done;
        logic [3:0][7:0] rb;

        c = (char_in >= 8'h61 && char_in <= 8'h7A) ? char_in - 8'd32 : char_in;
        eol = (c == CH_CR) || (c == CH_LF);
        hv = 1'b0;
        hn = 4'h0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            hv = 1'b1;
            hn = c[3:0];
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            hv = 1'b1;
            hn = c[3:0] + 4'd9;
        end

        cmd_next = cmd_reg;
        sub_next = sub_reg;
        mph_next = mph_reg;
        hph_next = hph_reg;
        data_next = data_reg;
        addr_next = addr_reg;
        len_next = len_reg;
        fresh_next = fresh_reg;

        if (cmd_reg == CMD_IDLE)
        begin
            addr_next = 8'h00;
            mph_next = PH_FIRST;
            data_next = 8'h00;
            len_next = 8'h01;
            fresh_next = 1'b1;
            cmd_next = CMD_GET;
            sub_next = SUB_ADDR;
        end
        fr0 = fresh_next;

        th_ok = 1'b0;
        th_err = 1'b0;
        th_hp = hph_next;
        th_db = data_next;
        if (hv && !hph_next)
        begin
            th_db = {hn, 4'h0};
            th_hp = 1'b1;
        end
        else if (hv && hph_next)
        begin
            th_db = data_next | {4'h0, hn};
            th_hp = 1'b0;
            th_ok = 1'b1;
        end
        else if (c == CH_SPACE && !hph_next)
        begin
            th_ok = 1'b0;
        end
        else
        begin
            th_hp = 1'b0;
            th_err = 1'b1;
        end

        n = 3'd0;
        err = ERR_NONE;
        done = 1'b0;
        rb = '0;
        dc_go = 1'b0;
        allow = 1'b0;

        case (cmd_next)
            CMD_GET:
            begin
                if (c == CH_S || c == CH_R || c == CH_W)
                begin
                    cmd_next = (c == CH_S) ? CMD_RAW : ((c == CH_R) ? CMD_READ : CMD_WRITE);
                    rb[n[1:0]] = CH_S; n = n + 3'd1;
                end
                else if (eol)
                begin
                    cmd_next = CMD_GET;
                end
                else if (c == CH_HASH)
                begin
                    cmd_next = CMD_COMMENT;
                end
                else
                begin
                    err = ERR_CMD;
                end
            end
            CMD_COMMENT:
            begin
                if (eol)
                begin
                    cmd_next = CMD_IDLE;
                end
            end
            CMD_RAW:
            begin
                case (sub_next)
                    SUB_ADDR, SUB_RD_LEN:
                    begin
                        hph_next = th_hp;
                        data_next = th_db;
                        if (th_err)
                        begin
                            err = ERR_HEX;
                        end
                        if (th_ok)
                        begin
                            rb[n[1:0]] = th_db; n = n + 3'd1;
                            if (sub_next == SUB_RD_LEN)
                            begin
                                sub_next = SUB_RS_STOP;
                            end
                            else
                            begin
                                sub_next = th_db[0] ? SUB_RD_LEN : SUB_WR_DATA;
                            end
                        end
                    end
                    SUB_RS_STOP:
                    begin
                        if (c == CH_S)
                        begin
                            rb[n[1:0]] = CH_S; n = n + 3'd1;
                            sub_next = SUB_ADDR;
                        end
                        else if (c == CH_P)
                        begin
                            rb[n[1:0]] = CH_P; n = n + 3'd1;
                            cmd_next = CMD_WAIT;
                        end
                    end
                    SUB_WR_DATA:
                    begin
                        dc_go = 1'b1;
                        allow = 1'b0;
                    end
                    default:
                    begin
                        dc_go = 1'b0;
                    end
                endcase
            end
            CMD_READ, CMD_WRITE:
            begin
                if (sub_next == SUB_ADDR)
                begin
                    hph_next = th_hp;
                    data_next = th_db;
                    if (th_err)
                    begin
                        err = ERR_HEX;
                    end
                    if (th_ok)
                    begin
                        addr_next = {th_db[7:1], 1'b0};
                        rb[n[1:0]] = {th_db[7:1], 1'b0}; n = n + 3'd1;
                        sub_next = SUB_REG;
                    end
                end
                else if (sub_next == SUB_REG)
                begin
                    hph_next = th_hp;
                    data_next = th_db;
                    if (th_err)
                    begin
                        err = ERR_HEX;
                    end
                    if (th_ok)
                    begin
                        rb[n[1:0]] = DATA_MARK; n = n + 3'd1;
                        rb[n[1:0]] = th_db; n = n + 3'd1;
                        if (cmd_next == CMD_READ)
                        begin
                            rb[n[1:0]] = CH_S; n = n + 3'd1;
                            rb[n[1:0]] = {addr_next[7:1], 1'b1}; n = n + 3'd1;
                            sub_next = SUB_LEN_EOL;
                        end
                        else
                        begin
                            sub_next = SUB_DATA_EOL;
                        end
                    end
                end
                else if (cmd_next == CMD_READ && sub_next == SUB_LEN_EOL)
                begin
                    if (hv && mph_next == PH_FIRST)
                    begin
                        len_next = {hn, 4'h0};
                        mph_next = PH_SECOND;
                    end
                    else if (hv && mph_next == PH_SECOND)
                    begin
                        len_next = len_next | {4'h0, hn};
                        mph_next = PH_FIRST;
                    end
                    else if (c == CH_SPACE && mph_next != PH_SECOND)
                    begin
                        done = 1'b0;
                    end
                    else if (eol && mph_next != PH_SECOND)
                    begin
                        rb[n[1:0]] = len_next; n = n + 3'd1;
                        rb[n[1:0]] = CH_P; n = n + 3'd1;
                        rb[n[1:0]] = CH_LF; n = n + 3'd1;
                        done = 1'b1;
                    end
                end
                else if (cmd_next == CMD_WRITE && sub_next == SUB_DATA_EOL)
                begin
                    dc_go = 1'b1;
                    allow = 1'b1;
                end
                else
                begin
                    err = ERR_INT;
                end
            end
            CMD_WAIT:
            begin
                if (eol)
                begin
                    rb[n[1:0]] = CH_LF; n = n + 3'd1;
                    done = 1'b1;
                end
            end
            default:
            begin
                err = ERR_INT;
            end
        endcase

        if (dc_go)
        begin
            if (c == CH_BSL && mph_next == PH_FIRST)
            begin
                mph_next = PH_ESCAPE;
            end
            else if (mph_next == PH_ESCAPE)
            begin
                rb[n[1:0]] = DATA_MARK; n = n + 3'd1;
                rb[n[1:0]] = char_in; n = n + 3'd1;
                mph_next = PH_FIRST;
            end
            else if (hv && mph_next == PH_FIRST)
            begin
                data_next = {hn, 4'h0};
                mph_next = PH_SECOND;
            end
            else if (hv && mph_next == PH_SECOND)
            begin
                data_next = data_next | {4'h0, hn};
                rb[n[1:0]] = DATA_MARK; n = n + 3'd1;
                rb[n[1:0]] = data_next; n = n + 3'd1;
                mph_next = PH_FIRST;
            end
            else if (!allow && c == CH_S && mph_next == PH_FIRST)
            begin
                rb[n[1:0]] = CH_S; n = n + 3'd1;
                sub_next = SUB_ADDR;
            end
            else if (!allow && c == CH_P && mph_next == PH_FIRST)
            begin
                rb[n[1:0]] = CH_P; n = n + 3'd1;
                cmd_next = CMD_WAIT;
            end
            else if (allow && eol && mph_next == PH_FIRST)
            begin
                rb[n[1:0]] = CH_P; n = n + 3'd1;
                rb[n[1:0]] = CH_LF; n = n + 3'd1;
                done = 1'b1;
            end
            else if (c == CH_SPACE && mph_next == PH_FIRST)
            begin
                done = 1'b0;
            end
            else
            begin
                err = ERR_DATA;
            end
        end

        fresh_next = fr0 && (n == 3'd0);
        if (err != ERR_NONE || done)
        begin
            cmd_next = CMD_IDLE;
        end

        res.cnt = (err != ERR_NONE) ? 3'd1 : n;
        res.err = err;
        res.done = done && (err == ERR_NONE);
        res.start = fr0 && (err == ERR_NONE);
        res.bytes = rb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg <= CMD_IDLE;
            sub_reg <= SUB_ADDR;
            mph_reg <= PH_FIRST;
            hph_reg <= 1'b0;
            data_reg <= 8'h00;
            addr_reg <= 8'h00;
            len_reg <= 8'h01;
            fresh_reg <= 1'b1;
        end
        else if (step)
        begin
            cmd_reg <= cmd_next;
            sub_reg <= sub_next;
            mph_reg <= mph_next;
            hph_reg <= hph_next;
            data_reg <= data_next;
            addr_reg <= addr_next;
            len_reg <= len_next;
            fresh_reg <= fresh_next;
        end
    end

endmodule

// ===== src/ahicp_emitter.sv =====
`timescale 1ns / 1ps
// Result register that holds the items of one character and sends them one per cycle while m_axis_tready is high.
// Depends on ahicp_pkg.
module ahicp_emitter
    import ahicp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  res_t        res,
    output logic        load_ok,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    res_t       res_reg;
    logic       is_last;
    logic       is_err;

    assign is_last = ({1'b0, idx_reg} + 3'd1) == res_reg.cnt;
    assign is_err = res_reg.err != ERR_NONE;
    assign load_ok = !busy_reg || (m_axis_tready && is_last);

    always_comb
    begin
        busy_next = busy_reg;
        idx_next = idx_reg;
        if (step && load_ok)
        begin
            busy_next = res.cnt != 3'd0;
            idx_next = 2'd0;
        end
        else if (load_ok)
        begin
            busy_next = 1'b0;
        end
        else if (m_axis_tready)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && load_ok)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata = {5'b0, res_reg.err, is_err ? 8'h00 : res_reg.bytes[idx_reg]};
    assign m_axis_tuser = {res_reg.done && is_last, res_reg.start && idx_reg == 2'd0, is_err};
    assign m_axis_tlast = is_last;

endmodule

// ===== tb/ahicp_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the ASCII hex I2C command parser: predicts the items of every accepted
// character and compares them with the output stream. Depends on ahicp_pkg.
module ahicp_checker
    import ahicp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    input  logic        char_ready,
    input  logic [7:0]  char_data,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic [15:0] res_data,
    input  logic [2:0]  res_user,
    input  logic        res_last,
    output int          fail_count,
    output int          outstanding
);

    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic [2:0] code;
        logic       start;
        logic       done;
        logic       last;
    } parse_item_t;

    parse_item_t expected_items[$];
    parse_item_t want;
    int          n_fail;

    logic [2:0] cmd_st;
    logic [2:0] sub_st;
    logic [1:0] nib_ph;
    logic       pair_ph;
    logic [7:0] acc;
    logic [7:0] dev_addr;
    logic [7:0] rd_len;
    logic       fresh;
    logic [2:0] err_hit;
    logic [7:0] put_val [4];
    logic       put_new [4];
    int         put_cnt;

    function automatic int nib_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return int'(c - "0");
        end
        if (c >= "A" && c <= "F")
        begin
            return int'(c - "A") + 10;
        end
        return -1;
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        if (put_cnt < 4)
        begin
            put_val[put_cnt] = b;
            put_new[put_cnt] = fresh;
            put_cnt++;
        end
        fresh = 1'b0;
    endfunction

    // Hex pair used for addresses, registers and raw read lengths.
    function automatic bit take_pair(input logic [7:0] c);
        int v;
        v = nib_of(c);
        if (v >= 0 && !pair_ph)
        begin
            acc = {v[3:0], 4'h0};
            pair_ph = 1'b1;
        end
        else if (v >= 0 && pair_ph)
        begin
            acc = acc | {4'h0, v[3:0]};
            pair_ph = 1'b0;
            return 1'b1;
        end
        else if (c == CH_SPACE && !pair_ph)
        begin
        end
        else
        begin
            pair_ph = 1'b0;
            err_hit = ERR_HEX;
        end
        return 1'b0;
    endfunction

    // Data phase of a raw write or a register write; returns 1 at the end of a register write line.
    function automatic bit data_item(input logic [7:0] c, input logic [7:0] raw,
                                     input bit allow_eol);
        int v;
        v = nib_of(c);
        if (c == CH_BSL && nib_ph == PH_FIRST)
        begin
            nib_ph = PH_ESCAPE;
        end
        else if (nib_ph == PH_ESCAPE)
        begin
            push_byte(DATA_MARK);
            push_byte(raw);
            nib_ph = PH_FIRST;
        end
        else if (v >= 0 && nib_ph == PH_FIRST)
        begin
            acc = {v[3:0], 4'h0};
            nib_ph = PH_SECOND;
        end
        else if (v >= 0 && nib_ph == PH_SECOND)
        begin
            acc = acc | {4'h0, v[3:0]};
            push_byte(DATA_MARK);
            push_byte(acc);
            nib_ph = PH_FIRST;
        end
        else if (!allow_eol && c == CH_S && nib_ph == PH_FIRST)
        begin
            push_byte(CH_S);
            sub_st = SUB_ADDR;
        end
        else if (!allow_eol && c == CH_P && nib_ph == PH_FIRST)
        begin
            push_byte(CH_P);
            cmd_st = CMD_WAIT;
        end
        else if (allow_eol && (c == CH_CR || c == CH_LF) && nib_ph == PH_FIRST)
        begin
            push_byte(CH_P);
            push_byte(CH_LF);
            return 1'b1;
        end
        else if (c == CH_SPACE && nib_ph == PH_FIRST)
        begin
        end
        else
        begin
            err_hit = ERR_DATA;
        end
        return 1'b0;
    endfunction

    task automatic predict_char(input logic [7:0] raw);
        logic [7:0]  c;
        bit          done;
        bit          eol;
        int          v;
        bit          fin;
        parse_item_t it;
        c = (raw >= "a" && raw <= "z") ? raw - 8'd32 : raw;
        eol = (c == CH_CR || c == CH_LF);
        done = 1'b0;
        err_hit = ERR_NONE;
        put_cnt = 0;
        if (cmd_st == CMD_IDLE)
        begin
            dev_addr = 8'h00;
            nib_ph = PH_FIRST;
            acc = 8'h00;
            rd_len = 8'h01;
            fresh = 1'b1;
            cmd_st = CMD_GET;
            sub_st = SUB_ADDR;
        end
        case (cmd_st)
            CMD_GET:
            begin
                if (c == CH_S)
                begin
                    cmd_st = CMD_RAW;
                    push_byte(CH_S);
                end
                else if (c == CH_R)
                begin
                    cmd_st = CMD_READ;
                    push_byte(CH_S);
                end
                else if (c == CH_W)
                begin
                    cmd_st = CMD_WRITE;
                    push_byte(CH_S);
                end
                else if (eol)
                begin
                end
                else if (c == CH_HASH)
                begin
                    cmd_st = CMD_COMMENT;
                end
                else
                begin
                    err_hit = ERR_CMD;
                end
            end
            CMD_COMMENT:
            begin
                if (eol)
                begin
                    cmd_st = CMD_IDLE;
                end
            end
            CMD_RAW:
            begin
                if (sub_st == SUB_ADDR)
                begin
                    if (take_pair(c))
                    begin
                        push_byte(acc);
                        sub_st = acc[0] ? SUB_RD_LEN : SUB_WR_DATA;
                    end
                end
                else if (sub_st == SUB_RD_LEN)
                begin
                    if (take_pair(c))
                    begin
                        push_byte(acc);
                        sub_st = SUB_RS_STOP;
                    end
                end
                else if (sub_st == SUB_RS_STOP)
                begin
                    if (c == CH_S)
                    begin
                        push_byte(CH_S);
                        sub_st = SUB_ADDR;
                    end
                    else if (c == CH_P)
                    begin
                        push_byte(CH_P);
                        cmd_st = CMD_WAIT;
                    end
                end
                else if (sub_st == SUB_WR_DATA)
                begin
                    void'(data_item(c, raw, 1'b0));
                end
            end
            CMD_READ, CMD_WRITE:
            begin
                if (sub_st == SUB_ADDR)
                begin
                    if (take_pair(c))
                    begin
                        dev_addr = acc & 8'hFE;
                        push_byte(dev_addr);
                        sub_st = SUB_REG;
                    end
                end
                else if (sub_st == SUB_REG)
                begin
                    if (take_pair(c))
                    begin
                        push_byte(DATA_MARK);
                        push_byte(acc);
                        if (cmd_st == CMD_READ)
                        begin
                            push_byte(CH_S);
                            push_byte(dev_addr | 8'h01);
                            sub_st = SUB_LEN_EOL;
                        end
                        else
                        begin
                            sub_st = SUB_DATA_EOL;
                        end
                    end
                end
                else if (cmd_st == CMD_READ && sub_st == SUB_LEN_EOL)
                begin
                    v = nib_of(c);
                    if (v >= 0 && nib_ph == PH_FIRST)
                    begin
                        rd_len = {v[3:0], 4'h0};
                        nib_ph = PH_SECOND;
                    end
                    else if (v >= 0 && nib_ph == PH_SECOND)
                    begin
                        rd_len = rd_len | {4'h0, v[3:0]};
                        nib_ph = PH_FIRST;
                    end
                    else if (c == CH_SPACE && nib_ph != PH_SECOND)
                    begin
                    end
                    else if (eol && nib_ph != PH_SECOND)
                    begin
                        push_byte(rd_len);
                        push_byte(CH_P);
                        push_byte(CH_LF);
                        done = 1'b1;
                    end
                end
                else if (cmd_st == CMD_WRITE && sub_st == SUB_DATA_EOL)
                begin
                    done = data_item(c, raw, 1'b1);
                end
                else
                begin
                    err_hit = ERR_INT;
                end
            end
            CMD_WAIT:
            begin
                if (eol)
                begin
                    push_byte(CH_LF);
                    done = 1'b1;
                end
            end
            default:
            begin
                err_hit = ERR_INT;
            end
        endcase
        if (err_hit != ERR_NONE)
        begin
            cmd_st = CMD_IDLE;
            it = '{kind: 1'b1, out_byte: 8'h00, code: err_hit, start: 1'b0, done: 1'b0,
                   last: 1'b1};
            expected_items.push_back(it);
        end
        else
        begin
            if (done)
            begin
                cmd_st = CMD_IDLE;
            end
            for (int k = 0; k < put_cnt; k++)
            begin
                fin = (k == put_cnt - 1);
                it = '{kind: 1'b0, out_byte: put_val[k], code: ERR_NONE, start: put_new[k],
                       done: fin && done, last: fin};
                expected_items.push_back(it);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_st = CMD_IDLE;
            sub_st = SUB_ADDR;
            nib_ph = PH_FIRST;
            pair_ph = 1'b0;
            acc = 8'h00;
            dev_addr = 8'h00;
            rd_len = 8'h01;
            fresh = 1'b1;
            n_fail = 0;
            expected_items.delete();
            fail_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_items.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                    begin
                        $display("unexpected item: tdata=%04h tuser=%03b tlast=%0d",
                                 res_data, res_user, res_last);
                    end
                end
                else
                begin
                    want = expected_items.pop_front();
                    if (res_user[0] !== want.kind || res_data[7:0] !== want.out_byte ||
                        res_data[10:8] !== want.code || res_data[15:11] !== 5'd0 ||
                        res_user[1] !== want.start || res_user[2] !== want.done ||
                        res_last !== want.last)
                    begin
                        n_fail++;
                        if (n_fail <= 10)
                        begin
                            $display("mismatch: expected kind=%0d byte=%02h err=%0d ",
                                     want.kind, want.out_byte, want.code,
                                     "start=%0d done=%0d last=%0d; ",
                                     want.start, want.done, want.last,
                                     "got tdata=%04h tuser=%03b tlast=%0d",
                                     res_data, res_user, res_last);
                        end
                    end
                end
            end
            if (char_valid && char_ready)
            begin
                predict_char(char_data);
            end
            fail_count <= n_fail;
            outstanding <= expected_items.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the ASCII hex I2C command parser: clock, reset, character stimulus,
// output back-pressure and verdict. Depends on ahicp_pkg, ahicp_checker and the block.
module tb_top
    import ahicp_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_CHARS   = 385;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int          fail_count;
    int          outstanding;
    int          idle_cycles = 0;
    bit          calm = 1'b0;
    int          hold_asked = 0;
    int          hold_done = 0;
    logic [7:0]  char_stream[$];

    ascii_hex_i2c_command_parser u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    ahicp_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (s_axis_tvalid),
        .char_ready  (s_axis_tready),
        .char_data   (s_axis_tdata),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res_data    (m_axis_tdata),
        .res_user    (m_axis_tuser),
        .res_last    (m_axis_tlast),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Output side: random stalls, plus one long hold-off on request.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_done)
            begin
                hold_done++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 19);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic logic [7:0] any_case(input logic [7:0] c);
        return ($urandom_range(0, 3) == 0) ? (c | 8'h20) : c;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return "0" + {4'h0, n};
        end
        return any_case("A" + {4'h0, n} - 8'd10);
    endfunction

    task automatic add_hex(input logic [7:0] b);
        char_stream.push_back(hex_digit(b[7:4]));
        char_stream.push_back(hex_digit(b[3:0]));
    endtask

    task automatic add_gap();
        if ($urandom_range(0, 9) < 3)
        begin
            char_stream.push_back(CH_SPACE);
        end
    endtask

    task automatic add_eol();
        char_stream.push_back(($urandom_range(0, 1) == 0) ? CH_LF : CH_CR);
    endtask

    task automatic add_data();
        if ($urandom_range(0, 3) == 0)
        begin
            char_stream.push_back(CH_BSL);
            char_stream.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            add_hex(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            char_stream.push_back(s[i]);
        end
    endtask

    task automatic gen_raw();
        int         legs;
        logic [7:0] a;
        legs = $urandom_range(1, 3);
        char_stream.push_back(any_case(CH_S));
        for (int l = 0; l < legs; l++)
        begin
            a = 8'($urandom_range(0, 255));
            add_gap();
            add_hex(a);
            if (a[0])
            begin
                add_gap();
                add_hex(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) == 0)
                begin
                    char_stream.push_back(any_case(CH_W));
                end
            end
            else
            begin
                repeat ($urandom_range(0, 3))
                begin
                    add_gap();
                    add_data();
                end
            end
            add_gap();
            char_stream.push_back(any_case((l == legs - 1) ? CH_P : CH_S));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            char_stream.push_back(any_case(CH_R));
        end
        add_eol();
    endtask

    task automatic gen_register(input bit is_read);
        char_stream.push_back(any_case(is_read ? CH_R : CH_W));
        add_gap();
        add_hex(8'($urandom_range(0, 255)));
        add_gap();
        add_hex(8'($urandom_range(0, 255)));
        if (is_read)
        begin
            repeat ($urandom_range(0, 2))
            begin
                add_gap();
                add_hex(8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            repeat ($urandom_range(0, 4))
            begin
                add_gap();
                add_data();
            end
        end
        add_gap();
        add_eol();
    endtask

    task automatic gen_comment();
        char_stream.push_back(CH_HASH);
        repeat ($urandom_range(0, 6))
        begin
            char_stream.push_back(8'($urandom_range(32, 126)));
        end
        add_eol();
    endtask

    task automatic gen_command(input int pick);
        if (pick < 25)
        begin
            gen_raw();
        end
        else if (pick < 50)
        begin
            gen_register(1'b1);
        end
        else if (pick < 75)
        begin
            gen_register(1'b0);
        end
        else if (pick < 90)
        begin
            gen_comment();
        end
        else
        begin
            add_eol();
        end
    endtask

    task automatic gen_random();
        int pick;
        int first;
        int idx;
        pick = $urandom_range(0, 99);
        if (pick < 72)
        begin
            gen_command($urandom_range(0, 99));
        end
        else if (pick < 82)
        begin
            repeat ($urandom_range(1, 4))
            begin
                char_stream.push_back(8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            // A well-formed command with one character replaced by an arbitrary byte.
            first = char_stream.size();
            gen_command($urandom_range(0, 99));
            idx = $urandom_range(first, char_stream.size() - 1);
            char_stream[idx] = 8'($urandom_range(0, 255));
        end
    endtask

    task automatic send_char(input logic [7:0] c);
        while (!calm && $urandom_range(0, 99) < 19)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
    endtask

    task automatic send_stream();
        for (int i = 0; i < char_stream.size(); i++)
        begin
            send_char(char_stream[i]);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: lower-case read with default length, escaped 0xFF in a write ended by
        // CR, a zero byte as a bad command, a bad hex digit, a comment and a raw read.
        add_text("r50a1\n");
        add_text("WFF00\\");
        char_stream.push_back(8'hFF);
        add_text("\r");
        char_stream.push_back(8'h00);
        add_text("S1G#\n");
        add_text("SA105P\n");
        send_stream();
        drain();

        char_stream.delete();
        while (char_stream.size() < RANDOM_CHARS)
        begin
            gen_random();
        end
        for (int i = 0; i < char_stream.size(); i++)
        begin
            if (i == 60)
            begin
                hold_asked <= hold_asked + 1;
            end
            if (i == 160)
            begin
                drain();
            end
            calm <= (i >= 220 && i < 310);
            send_char(char_stream[i]);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/ahicp_pkg.sv
src/ahicp_parser.sv
src/ahicp_emitter.sv
src/ascii_hex_i2c_command_parser.sv
tb/ahicp_checker.sv
tb/tb_top.sv
